[design/fhc_pkg.sv]
// fhc_pkg: shared types and constants for the four-level hysteresis classifier
// no dependencies; imported by every module of the block

package fhc_pkg;

  // field widths
  localparam int unsigned WeightW = 24;
  localparam int unsigned BandW   = 20;
  localparam int unsigned SumW    = 26;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  // level codes
  typedef enum logic [2:0] {
    LVL_UNKNOWN  = 3'd0,
    LVL_VERY_LOW = 3'd1,
    LVL_LOW      = 3'd2,
    LVL_MEDIUM   = 3'd3,
    LVL_HIGH     = 3'd4
  } lvl_t;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_VERY_LOW_BOUND    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LOW_MEDIUM_BOUND  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MEDIUM_HIGH_BOUND = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HYSTERESIS_BAND   = 2'd3;

  // reset values of the registers
  localparam logic signed [WeightW-1:0] VeryLowBoundRst    = 24'sd100;
  localparam logic signed [WeightW-1:0] LowMediumBoundRst  = 24'sd500;
  localparam logic signed [WeightW-1:0] MediumHighBoundRst = 24'sd1000;
  localparam logic [BandW-1:0]          HysteresisBandRst  = 20'd20;

  // threshold set seen by the decision logic
  typedef struct packed {
    logic signed [WeightW-1:0] very_low_bound;
    logic signed [WeightW-1:0] low_medium_bound;
    logic signed [WeightW-1:0] medium_high_bound;
    logic [BandW-1:0]          hysteresis_band;
  } cfg_t;

  // one result item
  typedef struct packed {
    lvl_t level;
    logic led_low;
    logic led_medium;
    logic led_high;
  } result_t;

endpackage

[design/fhc_cfg.sv]
// fhc_cfg: configuration register file (thresholds and hysteresis band)
// depends on fhc_pkg

module fhc_cfg import fhc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode the write onto one register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_VERY_LOW_BOUND:    cfg_nxt.very_low_bound    = cfg_data;
        REG_LOW_MEDIUM_BOUND:  cfg_nxt.low_medium_bound  = cfg_data;
        REG_MEDIUM_HIGH_BOUND: cfg_nxt.medium_high_bound = cfg_data;
        REG_HYSTERESIS_BAND:   cfg_nxt.hysteresis_band   = cfg_data[BandW-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.very_low_bound    <= VeryLowBoundRst;
      cfg_r.low_medium_bound  <= LowMediumBoundRst;
      cfg_r.medium_high_bound <= MediumHighBoundRst;
      cfg_r.hysteresis_band   <= HysteresisBandRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/fhc_decide.sv]
// fhc_decide: next-level decision and led decode for one weight item
// depends on fhc_pkg

module fhc_decide import fhc_pkg::*; (
  input  logic                      mode,
  input  logic signed [WeightW-1:0] weight,
  input  lvl_t                      held_level,
  input  cfg_t                      cfg,
  output result_t                   result
);

  logic signed [SumW-1:0] w_ext;
  logic signed [SumW-1:0] t1_ext, t2_ext, t3_ext, h_ext;
  logic signed [SumW-1:0] t1_up, t2_up, t3_up, t1_dn, t2_dn, t3_dn;
  logic up1, up2, up3, dn1, dn2, dn3;
  logic lt1, lt2, lt3;
  lvl_t lv;

  // widen everything so threshold plus or minus band never wraps
  assign w_ext  = SumW'(weight);
  assign t1_ext = SumW'(cfg.very_low_bound);
  assign t2_ext = SumW'(cfg.low_medium_bound);
  assign t3_ext = SumW'(cfg.medium_high_bound);
  assign h_ext  = $signed({{(SumW-BandW){1'b0}}, cfg.hysteresis_band});

  assign t1_up = t1_ext + h_ext;
  assign t2_up = t2_ext + h_ext;
  assign t3_up = t3_ext + h_ext;
  assign t1_dn = t1_ext - h_ext;
  assign t2_dn = t2_ext - h_ext;
  assign t3_dn = t3_ext - h_ext;

  // rising, falling and plain compares
  assign up1 = w_ext >= t1_up;
  assign up2 = w_ext >= t2_up;
  assign up3 = w_ext >= t3_up;
  assign dn1 = w_ext <= t1_dn;
  assign dn2 = w_ext <= t2_dn;
  assign dn3 = w_ext <= t3_dn;
  assign lt1 = w_ext < t1_ext;
  assign lt2 = w_ext < t2_ext;
  assign lt3 = w_ext < t3_ext;

  // level update, checks taken in fixed order per held level
  always_comb begin
    lv = held_level;
    if (mode) begin
      lv = LVL_UNKNOWN;
    end else begin
      unique case (held_level)
        LVL_UNKNOWN: begin
          priority if (lt1) lv = LVL_VERY_LOW;
          else if (lt2)     lv = LVL_LOW;
          else if (lt3)     lv = LVL_MEDIUM;
          else              lv = LVL_HIGH;
        end
        LVL_VERY_LOW: begin
          if (up3)      lv = LVL_HIGH;
          else if (up2) lv = LVL_MEDIUM;
          else if (up1) lv = LVL_LOW;
        end
        LVL_LOW: begin
          if (up3)      lv = LVL_HIGH;
          else if (up2) lv = LVL_MEDIUM;
          else if (dn1) lv = LVL_VERY_LOW;
        end
        LVL_MEDIUM: begin
          if (up3)      lv = LVL_HIGH;
          else if (dn1) lv = LVL_VERY_LOW;
          else if (dn2) lv = LVL_LOW;
        end
        LVL_HIGH: begin
          if (dn1)      lv = LVL_VERY_LOW;
          else if (dn2) lv = LVL_LOW;
          else if (dn3) lv = LVL_MEDIUM;
        end
        default: lv = LVL_UNKNOWN;
      endcase
    end
  end

  // led decode
  assign result.level      = lv;
  assign result.led_low    = (lv == LVL_VERY_LOW) || (lv == LVL_LOW);
  assign result.led_medium = (lv == LVL_MEDIUM);
  assign result.led_high   = (lv == LVL_HIGH);

endmodule

[design/four_level_hysteresis_classifier_unit.sv]
// four_level_hysteresis_classifier_unit: top level of the weight level classifier
// depends on fhc_pkg, fhc_cfg and fhc_decide

// Classifies signed whole-gram weight items into a held level (unknown, very
// low, low, medium, high) against three programmable thresholds with a
// hysteresis band, and drives three leds. An item with mode set clears the
// level to unknown. Each item gives exactly one result. The block takes one
// item per cycle while in_stall is low: an item is captured in an input register,
// the six band compares and the level update are combinational, and the result
// and the new held level are loaded together once the result register is free.
// A stalled result holds the input register, and only then is the input stalled.
// The user must write the registers through the cfg port only while no item is
// in flight; the block itself does not enforce this.

module four_level_hysteresis_classifier_unit import fhc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgDataW-1:0]       cfg_data,
  // input items
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_mode,
  input  logic signed [WeightW-1:0] in_weight,
  // result items
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_level,
  output logic                      out_led_low,
  output logic                      out_led_medium,
  output logic                      out_led_high
);

  cfg_t    cfg;
  result_t dec_result;

  logic                      s1_valid_r;
  logic                      s1_mode_r;
  logic signed [WeightW-1:0] s1_weight_r;
  logic                      out_valid_r;
  result_t                   out_result_r;
  lvl_t                      held_level_r;

  logic out_free;
  logic s1_move;
  logic in_take;

  // register file
  fhc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // decision logic between input and result registers
  fhc_decide u_decide (
    .mode       (s1_mode_r),
    .weight     (s1_weight_r),
    .held_level (held_level_r),
    .cfg        (cfg),
    .result     (dec_result)
  );

  // pipeline flow control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      held_level_r <= LVL_UNKNOWN;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_move;
      end
      if (s1_move) begin
        held_level_r <= dec_result.level;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r   <= in_mode;
      s1_weight_r <= in_weight;
    end
    if (s1_move) begin
      out_result_r <= dec_result;
    end
  end

  // result port
  assign out_valid      = out_valid_r;
  assign out_level      = out_result_r.level;
  assign out_led_low    = out_result_r.led_low;
  assign out_led_medium = out_result_r.led_medium;
  assign out_led_high   = out_result_r.led_high;

endmodule

[tb/sv/four_level_hysteresis_classifier_unit_test.sv]
// four_level_hysteresis_classifier_unit_test: self-checking testbench for the weight level classifier
// drives items and register writes, predicts each level and led result; depends on fhc_pkg

module four_level_hysteresis_classifier_unit_test import fhc_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  // item modes
  localparam logic MODE_CLASSIFY = 1'b0;
  localparam logic MODE_CLEAR    = 1'b1;

  // generous bound on the whole run, far above the slowest legal run
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CfgIdxW-1:0]        cfg_index;
  logic [CfgDataW-1:0]       cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_mode;
  logic signed [WeightW-1:0] in_weight;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [2:0]                out_level;
  logic                      out_led_low;
  logic                      out_led_medium;
  logic                      out_led_high;

  // predictor copy of the registers and the held level
  logic signed [WeightW-1:0] vl_bound;
  logic signed [WeightW-1:0] lm_bound;
  logic signed [WeightW-1:0] mh_bound;
  logic [BandW-1:0]          band;
  lvl_t                      tracked_level;

  result_t     pending_levels[$];
  int unsigned bad_result_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  four_level_hysteresis_classifier_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_weight      (in_weight),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_level      (out_level),
    .out_led_low    (out_led_low),
    .out_led_medium (out_led_medium),
    .out_led_high   (out_led_high)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("four_level_hysteresis_classifier_unit_test failed");
      $finish;
    end
  end

  // random result back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // level update for one item; advances the tracked level
  function automatic result_t predict_level(input logic mode,
                                            input logic signed [WeightW-1:0] weight);
    logic signed [SumW-1:0] w;
    logic signed [SumW-1:0] t1;
    logic signed [SumW-1:0] t2;
    logic signed [SumW-1:0] t3;
    logic signed [SumW-1:0] h;
    result_t                r;
    w  = SumW'(weight);
    t1 = SumW'(vl_bound);
    t2 = SumW'(lm_bound);
    t3 = SumW'(mh_bound);
    h  = SumW'($signed({1'b0, band}));
    if (mode == MODE_CLEAR) begin
      tracked_level = LVL_UNKNOWN;
    end else begin
      case (tracked_level)
        // first sample: plain compare, no band
        LVL_UNKNOWN: begin
          if (w < t1) tracked_level = LVL_VERY_LOW;
          else if (w < t2) tracked_level = LVL_LOW;
          else if (w < t3) tracked_level = LVL_MEDIUM;
          else tracked_level = LVL_HIGH;
        end
        LVL_VERY_LOW: begin
          if (w >= t3 + h) tracked_level = LVL_HIGH;
          else if (w >= t2 + h) tracked_level = LVL_MEDIUM;
          else if (w >= t1 + h) tracked_level = LVL_LOW;
        end
        LVL_LOW: begin
          if (w >= t3 + h) tracked_level = LVL_HIGH;
          else if (w >= t2 + h) tracked_level = LVL_MEDIUM;
          else if (w <= t1 - h) tracked_level = LVL_VERY_LOW;
        end
        LVL_MEDIUM: begin
          if (w >= t3 + h) tracked_level = LVL_HIGH;
          else if (w <= t1 - h) tracked_level = LVL_VERY_LOW;
          else if (w <= t2 - h) tracked_level = LVL_LOW;
        end
        LVL_HIGH: begin
          if (w <= t1 - h) tracked_level = LVL_VERY_LOW;
          else if (w <= t2 - h) tracked_level = LVL_LOW;
          else if (w <= t3 - h) tracked_level = LVL_MEDIUM;
        end
        default: begin
          tracked_level = LVL_UNKNOWN;
        end
      endcase
    end
    r.level      = tracked_level;
    r.led_low    = (tracked_level == LVL_VERY_LOW) || (tracked_level == LVL_LOW);
    r.led_medium = (tracked_level == LVL_MEDIUM);
    r.led_high   = (tracked_level == LVL_HIGH);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [2:0] want,
                                      input logic [2:0] got);
    if (got !== want) begin
      bad_result_count++;
      if (bad_result_count <= MaxReports)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_levels.size() == 0) begin
        bad_result_count++;
        if (bad_result_count <= MaxReports)
          $display("result with no item pending: level %0d", out_level);
      end else begin
        want = pending_levels.pop_front();
        check_field("level", want.level, out_level);
        check_field("led_low", 3'(want.led_low), 3'(out_led_low));
        check_field("led_medium", 3'(want.led_medium), 3'(out_led_medium));
        check_field("led_high", 3'(want.led_high), 3'(out_led_high));
      end
    end
  end

  // send one item; entered and left just after a falling edge, valid left high
  task automatic send_item(input logic mode, input logic signed [WeightW-1:0] weight);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_weight <= weight;
    // items are taken in order, so the expectation can be queued now
    pending_levels.push_back(predict_level(mode, weight));
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // program all four registers while the block is idle
  task automatic write_bounds(input logic signed [WeightW-1:0] vl,
                              input logic signed [WeightW-1:0] lm,
                              input logic signed [WeightW-1:0] mh,
                              input logic [CfgDataW-1:0] band_word);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_VERY_LOW_BOUND;
    cfg_data  <= vl;
    @(negedge clk);
    cfg_index <= REG_LOW_MEDIUM_BOUND;
    cfg_data  <= lm;
    @(negedge clk);
    cfg_index <= REG_MEDIUM_HIGH_BOUND;
    cfg_data  <= mh;
    @(negedge clk);
    cfg_index <= REG_HYSTERESIS_BAND;
    cfg_data  <= band_word;
    @(negedge clk);
    cfg_we   <= 1'b0;
    vl_bound = vl;
    lm_bound = lm;
    mh_bound = mh;
    band     = band_word[BandW-1:0];
  endtask

  // weight close to a threshold or to a threshold plus or minus the band
  function automatic logic signed [WeightW-1:0] pick_weight();
    int         bound;
    int         center;
    logic [31:0] raw;
    case ($urandom_range(2))
      0:       bound = int'(vl_bound);
      1:       bound = int'(lm_bound);
      default: bound = int'(mh_bound);
    endcase
    case ($urandom_range(2))
      0:       center = bound - int'(band);
      1:       center = bound;
      default: center = bound + int'(band);
    endcase
    raw = center + int'($urandom_range(8)) - 4;
    return raw[WeightW-1:0];
  endfunction

  // mostly near-threshold samples, some full-range ones and a few clears
  task automatic run_random(input int unsigned count);
    int unsigned pick;
    logic [31:0] raw;
    repeat (count) begin
      pick = $urandom_range(99);
      raw  = $urandom;
      if (pick < 6) send_item(MODE_CLEAR, raw[WeightW-1:0]);
      else if (pick < 22) send_item(MODE_CLASSIFY, raw[WeightW-1:0]);
      else send_item(MODE_CLASSIFY, pick_weight());
    end
  endtask

  // walk every level edge under the reset thresholds (100, 500, 1000, band 20)
  task automatic test_level_walk();
    send_item(MODE_CLASSIFY, -24'sd8388608);
    send_item(MODE_CLASSIFY, 24'sd119);
    send_item(MODE_CLASSIFY, 24'sd120);
    send_item(MODE_CLASSIFY, 24'sd519);
    send_item(MODE_CLASSIFY, 24'sd520);
    send_item(MODE_CLASSIFY, 24'sd1019);
    send_item(MODE_CLASSIFY, 24'sd1020);
    send_item(MODE_CLASSIFY, 24'sd981);
    send_item(MODE_CLASSIFY, 24'sd980);
    send_item(MODE_CLASSIFY, 24'sd481);
    send_item(MODE_CLASSIFY, 24'sd480);
    send_item(MODE_CLASSIFY, 24'sd81);
    send_item(MODE_CLASSIFY, 24'sd80);
    // clear ignores the weight; next sample classified with no band
    send_item(MODE_CLEAR, 24'sd8388607);
    send_item(MODE_CLASSIFY, 24'sd100);
    send_item(MODE_CLEAR, -24'sd8388608);
    send_item(MODE_CLASSIFY, 24'sd8388607);
    // jumps across several levels
    send_item(MODE_CLASSIFY, 24'sd80);
    send_item(MODE_CLASSIFY, 24'sd1020);
    send_item(MODE_CLEAR, 24'sd0);
    send_item(MODE_CLASSIFY, 24'sd500);
    send_item(MODE_CLASSIFY, 24'sd80);
    send_item(MODE_CLEAR, 24'sd0);
    send_item(MODE_CLASSIFY, 24'sd999);
    send_item(MODE_CLASSIFY, 24'sd99);
  endtask

  task automatic test_default_bounds();
    run_random(75);
  endtask

  // thresholds at the weight extremes, first with the widest band and unused band bits set, then with a zero band
  task automatic test_extreme_bounds();
    write_bounds(-24'sd8388608, 24'sd0, 24'sd8388607, 24'hFFFFFF);
    run_random(40);
    write_bounds(-24'sd8388608, -24'sd8388608, 24'sd8388607, 24'h000000);
    run_random(35);
  endtask

  // thresholds out of order: decisions keep their fixed order
  task automatic test_unordered_bounds();
    logic [3:0] junk;
    junk = 4'($urandom);
    write_bounds(24'sd3000, -24'sd200, 24'sd700, {junk, 20'd50});
    run_random(75);
  endtask

  // several random ordered threshold sets with small bands
  task automatic test_random_bounds();
    int         t1;
    int         t2;
    int         t3;
    logic [3:0] junk;
    repeat (3) begin
      t1   = int'($urandom_range(2000)) - 1000;
      t2   = t1 + int'($urandom_range(600, 1));
      t3   = t2 + int'($urandom_range(600, 1));
      junk = 4'($urandom);
      write_bounds(WeightW'(t1), WeightW'(t2), WeightW'(t3),
                   {junk, 20'($urandom_range(200))});
      run_random(25);
    end
  endtask

  task automatic test_zero_band();
    write_bounds(-24'sd50, 24'sd0, 24'sd50, 24'd0);
    run_random(75);
  endtask

  task automatic test_wide_band();
    write_bounds(-24'sd4000000, 24'sd0, 24'sd4000000, 24'd1000000);
    run_random(75);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_VERY_LOW_BOUND;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_mode   = MODE_CLASSIFY;
    in_weight = '0;
    vl_bound  = VeryLowBoundRst;
    lm_bound  = LowMediumBoundRst;
    mh_bound  = MediumHighBoundRst;
    band      = HysteresisBandRst;
    tracked_level    = LVL_UNKNOWN;
    bad_result_count = 0;
    cycle_count      = 0;
    send_idle_pct    = 32;
    recv_idle_pct    = 72;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_level_walk();
    test_default_bounds();
    test_extreme_bounds();

    send_idle_pct = 72;
    recv_idle_pct = 32;
    test_unordered_bounds();
    test_random_bounds();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_zero_band();
    test_wide_band();

    // let the last results out
    drain_results();
    repeat (10) @(negedge clk);
    if (bad_result_count == 0 && pending_levels.size() == 0)
      $display("four_level_hysteresis_classifier_unit_test passed");
    else
      $display("four_level_hysteresis_classifier_unit_test failed");
    $finish;
  end

endmodule

[files.f]
design/fhc_pkg.sv
design/fhc_cfg.sv
design/fhc_decide.sv
design/four_level_hysteresis_classifier_unit.sv
tb/sv/four_level_hysteresis_classifier_unit_test.sv
